### rtl/core/midi_byte_stream_note_tracker_macros.svh
// assertion macros used by the checker file
`ifndef MIDI_BYTE_STREAM_NOTE_TRACKER_MACROS_SVH
`define MIDI_BYTE_STREAM_NOTE_TRACKER_MACROS_SVH

// clocked property, off while reset is asserted
`define MBSNT_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// a condition at one edge keeps a signal unchanged at the next edge
`define MBSNT_HOLD(name, cond, sig, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) cond |=> $stable(sig)) \
        else $error(msg);

`endif

### rtl/core/mbsnt_pkg.sv
// package: shared types, codes and the program-to-preset table
`timescale 1ns / 1ps
package mbsnt_pkg;

    localparam int DEF_STACK_DEPTH   = 4;
    localparam int DEF_CHANNEL_COUNT = 16;
    localparam int DEF_NOTE_COUNT    = 128;
    localparam int RESULT_CAP        = 4;
    localparam int QUEUE_DEPTH       = 4;
    localparam int QUEUE_AW          = 2;
    localparam int SERIAL_W          = 32;

    // message kinds from the parser
    localparam logic [3:0] MSG_NOTE_ON    = 4'd0;
    localparam logic [3:0] MSG_NOTE_OFF   = 4'd1;
    localparam logic [3:0] MSG_PRESSURE   = 4'd2;
    localparam logic [3:0] MSG_MOD        = 4'd3;
    localparam logic [3:0] MSG_SUSTAIN    = 4'd4;
    localparam logic [3:0] MSG_BEND       = 4'd5;
    localparam logic [3:0] MSG_PRESET     = 4'd6;
    localparam logic [3:0] MSG_SOUND_OFF  = 4'd7;
    localparam logic [3:0] MSG_NOTES_OFF  = 4'd8;
    localparam logic [3:0] MSG_CTRL_RESET = 4'd9;

    // output command codes
    localparam logic [3:0] CMD_NOTE_ON       = 4'd0;
    localparam logic [3:0] CMD_NOTE_OFF      = 4'd1;
    localparam logic [3:0] CMD_POLY_PRESSURE = 4'd2;
    localparam logic [3:0] CMD_MODULATION    = 4'd3;
    localparam logic [3:0] CMD_SUSTAIN       = 4'd4;
    localparam logic [3:0] CMD_PITCH_BEND    = 4'd5;
    localparam logic [3:0] CMD_SET_PRESET    = 4'd6;
    localparam logic [3:0] CMD_ALL_SOUND_OFF = 4'd7;
    localparam logic [3:0] CMD_ALL_NOTES_OFF = 4'd8;

    // status and controller numbers
    localparam logic [7:0] BYTE_REALTIME = 8'hF8;
    localparam logic [7:0] BYTE_RESET    = 8'hFF;
    localparam logic [7:0] BYTE_SYSEX    = 8'hF0;
    localparam logic [7:0] BYTE_MTC      = 8'hF1;
    localparam logic [7:0] BYTE_SONG_POS = 8'hF2;
    localparam logic [7:0] BYTE_SONG_SEL = 8'hF3;
    localparam logic [3:0] TYPE_NOTE_OFF = 4'h8;
    localparam logic [3:0] TYPE_NOTE_ON  = 4'h9;
    localparam logic [3:0] TYPE_POLY     = 4'hA;
    localparam logic [3:0] TYPE_CC       = 4'hB;
    localparam logic [3:0] TYPE_PROGRAM  = 4'hC;
    localparam logic [3:0] TYPE_CHAN_PR  = 4'hD;
    localparam logic [3:0] TYPE_BEND     = 4'hE;
    localparam logic [6:0] CC_MOD        = 7'd1;
    localparam logic [6:0] CC_SUSTAIN    = 7'd64;
    localparam logic [6:0] CC_SOUND_OFF  = 7'd120;
    localparam logic [6:0] CC_CTRL_RESET = 7'd121;
    localparam logic [6:0] CC_NOTES_OFF  = 7'd123;

    typedef struct packed {
        logic [3:0] kind;
        logic [3:0] chan;
        logic [6:0] a;
        logic [6:0] b;
    } msg_t;

    typedef struct packed {
        logic [3:0]          code;
        logic                has_id;
        logic [SERIAL_W-1:0] serial;
        logic [6:0]          note;
        logic [6:0]          amount;
        logic [13:0]         bend;
        logic [4:0]          preset;
    } result_t;

    // general midi program to preset code
    function automatic logic [4:0] preset_of(input logic [6:0] p);
        logic [4:0] r;
        r = 5'd0;
        if (p inside {[7'd4:7'd5]}) r = 5'd1;
        else if (p == 7'd6) r = 5'd2;
        else if (p == 7'd10) r = 5'd3;
        else if (p == 7'd11) r = 5'd4;
        else if (p == 7'd16) r = 5'd5;
        else if (p inside {[7'd17:7'd23]}) r = 5'd6;
        else if (p inside {[7'd24:7'd27]}) r = 5'd7;
        else if (p inside {[7'd28:7'd31]}) r = 5'd8;
        else if (p inside {[7'd32:7'd39]}) r = 5'd9;
        else if (p inside {[7'd40:7'd41]}) r = 5'd10;
        else if (p inside {[7'd42:7'd43]}) r = 5'd11;
        else if (p == 7'd46) r = 5'd12;
        else if (p inside {[7'd52:7'd54]}) r = 5'd13;
        else if (p inside {[7'd71:7'd72]}) r = 5'd14;
        else if (p inside {[7'd73:7'd79]}) r = 5'd15;
        else if (p inside {[7'd80:7'd87]}) r = 5'd16;
        else if (p inside {[7'd88:7'd95]}) r = 5'd17;
        return r;
    endfunction

endpackage

### rtl/core/midi_byte_stream_note_tracker.sv
// path: a byte's message passes the queue, msg_reg, the row read, res_reg and the output
// register before its first word shows; the executor finishes one message (read, execute,
// emit its words) before it pops the next; a 4-deep queue lets the parser run ahead
// reset: after rst_n rises a sweep over all CHANNEL_COUNT*NOTE_COUNT rows (2048)
// clears the stack rows with s_tready low; all-sound-off and all-notes-off
// run the same sweep, input not held off, once their word is in the output register
`timescale 1ns / 1ps
module midi_byte_stream_note_tracker #(
    parameter int STACK_DEPTH   = mbsnt_pkg::DEF_STACK_DEPTH,
    parameter int CHANNEL_COUNT = mbsnt_pkg::DEF_CHANNEL_COUNT,
    parameter int NOTE_COUNT    = mbsnt_pkg::DEF_NOTE_COUNT
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,    // midi_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    // command_code, gid, note_number, amount, bend_value, preset_code, zero pad
    output logic [103:0] m_tdata,
    output logic         m_tlast,    // last_of_run
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam logic REG_SOURCE  = 1'b0;
    localparam logic REG_CHANNEL = 1'b1;

    logic [31:0]     source_number_reg;
    logic [4:0]      channel_select_reg;
    logic            q_full;
    logic            q_empty;
    logic            push;
    logic            pop;
    mbsnt_pkg::msg_t push_msg;
    mbsnt_pkg::msg_t head_msg;
    logic            init_done;
    logic [3:0]      code;
    logic [63:0]     gid;
    logic [6:0]      note;
    logic [6:0]      amount;
    logic [13:0]     bend;
    logic [4:0]      preset;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_number_reg  <= 32'd0;
            channel_select_reg <= 5'd0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_SOURCE)
                source_number_reg <= cfg_data;
            else if (cfg_index == REG_CHANNEL)
                channel_select_reg <= cfg_data[4:0];
        end
    end

    mbsnt_front #(
        .CHANNEL_COUNT (CHANNEL_COUNT),
        .NOTE_COUNT    (NOTE_COUNT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_byte     (s_tdata),
        .in_ready    (s_tready),
        .enable      (init_done),
        .chan_select (channel_select_reg),
        .q_full      (q_full),
        .push        (push),
        .push_msg    (push_msg)
    );

    mbsnt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_msg (push_msg),
        .pop      (pop),
        .head_msg (head_msg),
        .empty    (q_empty),
        .full     (q_full)
    );

    mbsnt_back #(
        .STACK_DEPTH   (STACK_DEPTH),
        .CHANNEL_COUNT (CHANNEL_COUNT),
        .NOTE_COUNT    (NOTE_COUNT)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_msg         (head_msg),
        .pop           (pop),
        .source_number (source_number_reg),
        .init_done     (init_done),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_code      (code),
        .out_gid       (gid),
        .out_note      (note),
        .out_amount    (amount),
        .out_bend      (bend),
        .out_preset    (preset),
        .out_last      (m_tlast)
    );

    // pack the output word
    assign m_tdata = {3'd0, preset, bend, amount, note, gid, code};

endmodule

### rtl/core/mbsnt_front.sv
// front end: byte parser with running status, channel filter, message classing
`timescale 1ns / 1ps
module mbsnt_front #(
    parameter int CHANNEL_COUNT = mbsnt_pkg::DEF_CHANNEL_COUNT,
    parameter int NOTE_COUNT    = mbsnt_pkg::DEF_NOTE_COUNT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [7:0]        in_byte,
    output logic              in_ready,
    input  logic              enable,
    input  logic [4:0]        chan_select,
    input  logic              q_full,
    output logic              push,
    output mbsnt_pkg::msg_t   push_msg
);

    logic [7:0] status_reg;
    logic [1:0] needed_reg;
    logic       held_reg;
    logic [6:0] first_reg;
    logic       sysex_reg;
    logic [1:0] skip_reg;

    logic       accept;
    logic       sel_ok;
    logic [3:0] chan;
    logic [3:0] mtype;
    logic [6:0] a;
    logic [6:0] b;
    logic       data_msg;
    logic       chan_ok;
    logic       note_ok;
    logic       has_msg;
    logic [3:0] kind;
    logic [6:0] kb;

    assign in_ready = !q_full && enable;
    assign accept   = in_valid && in_ready;
    assign sel_ok   = (chan_select <= 5'd16);

    // operands of a complete channel message
    assign chan  = status_reg[3:0];
    assign mtype = status_reg[7:4];
    assign a     = (needed_reg == 2'd2) ? first_reg : in_byte[6:0];
    assign b     = (needed_reg == 2'd2) ? in_byte[6:0] : 7'd0;
    assign data_msg = !in_byte[7] && !sysex_reg && (skip_reg == 2'd0) &&
                      (status_reg != 8'd0) && !(!held_reg && (needed_reg == 2'd2));
    assign chan_ok = ((chan_select == 5'd0) || (chan_select == ({1'b0, chan} + 5'd1))) &&
                     (32'(chan) < CHANNEL_COUNT);
    assign note_ok = (32'(a) < NOTE_COUNT);

    // classify into a message for the back end
    always_comb
    begin
        has_msg = 1'b0;
        kind    = mbsnt_pkg::MSG_MOD;
        kb      = b;
        if (in_byte == mbsnt_pkg::BYTE_RESET)
        begin
            has_msg = 1'b1;
            kind    = mbsnt_pkg::MSG_CTRL_RESET;
        end
        else if (data_msg && chan_ok)
        begin
            case (mtype)
                mbsnt_pkg::TYPE_NOTE_OFF:
                begin
                    has_msg = note_ok;
                    kind    = mbsnt_pkg::MSG_NOTE_OFF;
                end
                mbsnt_pkg::TYPE_NOTE_ON:
                begin
                    has_msg = note_ok;
                    kind    = (b != 7'd0) ? mbsnt_pkg::MSG_NOTE_ON : mbsnt_pkg::MSG_NOTE_OFF;
                end
                mbsnt_pkg::TYPE_POLY:
                begin
                    has_msg = note_ok;
                    kind    = mbsnt_pkg::MSG_PRESSURE;
                end
                mbsnt_pkg::TYPE_CC:
                begin
                    has_msg = 1'b1;
                    if (a == mbsnt_pkg::CC_MOD) kind = mbsnt_pkg::MSG_MOD;
                    else if (a == mbsnt_pkg::CC_SUSTAIN) kind = mbsnt_pkg::MSG_SUSTAIN;
                    else if (a == mbsnt_pkg::CC_CTRL_RESET) kind = mbsnt_pkg::MSG_CTRL_RESET;
                    else if (a == mbsnt_pkg::CC_SOUND_OFF) kind = mbsnt_pkg::MSG_SOUND_OFF;
                    else if (a == mbsnt_pkg::CC_NOTES_OFF) kind = mbsnt_pkg::MSG_NOTES_OFF;
                    else has_msg = 1'b0;
                end
                mbsnt_pkg::TYPE_PROGRAM:
                begin
                    has_msg = 1'b1;
                    kind    = mbsnt_pkg::MSG_PRESET;
                end
                mbsnt_pkg::TYPE_BEND:
                begin
                    has_msg = 1'b1;
                    kind    = mbsnt_pkg::MSG_BEND;
                end
                default:
                begin
                    has_msg = 1'b0;
                end
            endcase
        end
    end

    assign push          = accept && sel_ok && has_msg;
    assign push_msg.kind = kind;
    assign push_msg.chan = chan;
    assign push_msg.a    = a;
    assign push_msg.b    = kb;

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg <= 8'd0;
            needed_reg <= 2'd0;
            held_reg   <= 1'b0;
            first_reg  <= 7'd0;
            sysex_reg  <= 1'b0;
            skip_reg   <= 2'd0;
        end
        else if (accept && sel_ok)
        begin
            if (in_byte >= mbsnt_pkg::BYTE_REALTIME)
            begin
                status_reg <= status_reg;
            end
            else if (in_byte[7])
            begin
                held_reg <= 1'b0;
                if (in_byte < mbsnt_pkg::BYTE_SYSEX)
                begin
                    sysex_reg  <= 1'b0;
                    skip_reg   <= 2'd0;
                    status_reg <= in_byte;
                    needed_reg <= (in_byte[7:4] == mbsnt_pkg::TYPE_PROGRAM ||
                                   in_byte[7:4] == mbsnt_pkg::TYPE_CHAN_PR) ? 2'd1 : 2'd2;
                end
                else
                begin
                    status_reg <= 8'd0;
                    needed_reg <= 2'd0;
                    sysex_reg  <= (in_byte == mbsnt_pkg::BYTE_SYSEX);
                    if (in_byte == mbsnt_pkg::BYTE_MTC || in_byte == mbsnt_pkg::BYTE_SONG_SEL)
                        skip_reg <= 2'd1;
                    else if (in_byte == mbsnt_pkg::BYTE_SONG_POS)
                        skip_reg <= 2'd2;
                    else
                        skip_reg <= 2'd0;
                end
            end
            else if (sysex_reg)
            begin
                sysex_reg <= 1'b1;
            end
            else if (skip_reg != 2'd0)
            begin
                skip_reg <= skip_reg - 2'd1;
            end
            else if (status_reg != 8'd0)
            begin
                if (!held_reg && needed_reg == 2'd2)
                begin
                    first_reg <= in_byte[6:0];
                    held_reg  <= 1'b1;
                end
                else
                begin
                    held_reg <= 1'b0;
                end
            end
        end
    end

endmodule

### rtl/core/mbsnt_queue.sv
// short message queue between parser and executor
`timescale 1ns / 1ps
module mbsnt_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  mbsnt_pkg::msg_t push_msg,
    input  logic            pop,
    output mbsnt_pkg::msg_t head_msg,
    output logic            empty,
    output logic            full
);

    mbsnt_pkg::msg_t                 entry_reg [mbsnt_pkg::QUEUE_DEPTH];
    logic [mbsnt_pkg::QUEUE_AW-1:0]  wr_ptr_reg;
    logic [mbsnt_pkg::QUEUE_AW-1:0]  rd_ptr_reg;
    logic [mbsnt_pkg::QUEUE_AW:0]    count_reg;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == (mbsnt_pkg::QUEUE_AW + 1)'(mbsnt_pkg::QUEUE_DEPTH));
    assign head_msg = entry_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push && !full)
            entry_reg[wr_ptr_reg] <= push_msg;
    end

    // pointers and fill
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push && !full)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop && !empty)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if ((push && !full) && !(pop && !empty))
                count_reg <= count_reg + 1'b1;
            else if (!(push && !full) && (pop && !empty))
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

### rtl/core/mbsnt_back.sv
// back end: per-key gesture stacks, result list and output register
`timescale 1ns / 1ps
module mbsnt_back #(
    parameter int STACK_DEPTH   = mbsnt_pkg::DEF_STACK_DEPTH,
    parameter int CHANNEL_COUNT = mbsnt_pkg::DEF_CHANNEL_COUNT,
    parameter int NOTE_COUNT    = mbsnt_pkg::DEF_NOTE_COUNT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  mbsnt_pkg::msg_t   q_msg,
    output logic              pop,
    input  logic [31:0]       source_number,
    output logic              init_done,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [3:0]        out_code,
    output logic [63:0]       out_gid,
    output logic [6:0]        out_note,
    output logic [6:0]        out_amount,
    output logic [13:0]       out_bend,
    output logic [4:0]        out_preset,
    output logic              out_last
);

    localparam int KEY_COUNT = CHANNEL_COUNT * NOTE_COUNT;
    localparam int KEY_W     = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    localparam int DEPTH_W   = $clog2(STACK_DEPTH + 1);
    localparam int SW        = mbsnt_pkg::SERIAL_W;
    localparam int ROW_W     = DEPTH_W + STACK_DEPTH * SW;
    localparam int PRESS_N   = (STACK_DEPTH < mbsnt_pkg::RESULT_CAP) ?
                               STACK_DEPTH : mbsnt_pkg::RESULT_CAP;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_EXEC  = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0]          state_reg;
    mbsnt_pkg::msg_t     msg_reg;
    logic [ROW_W-1:0]    row_reg;
    logic [KEY_W-1:0]    clr_addr_reg;
    logic                clear_pend_reg;
    logic                init_done_reg;
    logic [SW-1:0]       serial_reg;
    mbsnt_pkg::result_t  res_reg [mbsnt_pkg::RESULT_CAP];
    logic [2:0]          cnt_reg;
    logic [1:0]          idx_reg;
    logic                out_valid_reg;
    mbsnt_pkg::result_t  out_res_reg;
    logic [63:0]         out_gid_reg;
    logic                out_last_reg;

    logic [ROW_W-1:0]    row_mem [KEY_COUNT];

    logic [KEY_W-1:0]    key;
    logic [DEPTH_W-1:0]  d;
    logic [DEPTH_W-1:0]  d1;
    logic [SW-1:0]       s  [STACK_DEPTH];
    logic [SW-1:0]       ns [STACK_DEPTH];
    logic [SW-1:0]       top_serial;
    logic [DEPTH_W-1:0]  nd;
    mbsnt_pkg::result_t  rs [mbsnt_pkg::RESULT_CAP];
    logic [2:0]          cnt;
    logic                key_wr;
    logic                clr;
    logic [SW-1:0]       serial_inc;
    logic [SW-1:0]       next_serial;
    logic [ROW_W-1:0]    new_row;
    logic                mem_we;
    logic [KEY_W-1:0]    mem_wa;
    logic [ROW_W-1:0]    mem_wd;
    logic                load_ok;
    logic                is_last;

    function automatic mbsnt_pkg::result_t mk_res(input logic [3:0] code, input logic has_id,
                                                  input logic [SW-1:0] serial,
                                                  input logic [6:0] note,
                                                  input logic [6:0] amount);
        mbsnt_pkg::result_t r;
        r        = '0;
        r.code   = code;
        r.has_id = has_id;
        r.serial = serial;
        r.note   = note;
        r.amount = amount;
        return r;
    endfunction

    assign key = KEY_W'(32'(msg_reg.chan) * NOTE_COUNT + 32'(msg_reg.a));
    assign d   = row_reg[ROW_W-1 -: DEPTH_W];

    // unpack the stored row
    always_comb
    begin
        for (int i = 0; i < STACK_DEPTH; i++)
            s[i] = row_reg[i*SW +: SW];
    end

    // work out the results and the new row of one message
    always_comb
    begin
        for (int i = 0; i < mbsnt_pkg::RESULT_CAP; i++)
            rs[i] = '0;
        for (int i = 0; i < STACK_DEPTH; i++)
            ns[i] = s[i];
        cnt         = 3'd0;
        nd          = d;
        d1          = d;
        key_wr      = 1'b0;
        clr         = 1'b0;
        top_serial  = s[0];
        serial_inc  = serial_reg + 1'b1;
        next_serial = serial_reg;
        for (int i = 0; i < STACK_DEPTH; i++)
            if (DEPTH_W'(i + 1) == d)
                top_serial = s[i];
        case (msg_reg.kind)
            mbsnt_pkg::MSG_NOTE_ON:
            begin
                key_wr      = 1'b1;
                next_serial = (serial_inc == '0) ? SW'(1) : serial_inc;
                if (32'(d) >= STACK_DEPTH)
                begin
                    rs[0] = mk_res(mbsnt_pkg::CMD_NOTE_OFF, 1'b1, s[0], msg_reg.a, 7'd0);
                    rs[1] = mk_res(mbsnt_pkg::CMD_NOTE_ON, 1'b1, serial_reg, msg_reg.a,
                                   msg_reg.b);
                    cnt   = 3'd2;
                    for (int i = 0; i < STACK_DEPTH - 1; i++)
                        ns[i] = s[i + 1];
                    d1 = DEPTH_W'(STACK_DEPTH - 1);
                end
                else
                begin
                    rs[0] = mk_res(mbsnt_pkg::CMD_NOTE_ON, 1'b1, serial_reg, msg_reg.a,
                                   msg_reg.b);
                    cnt   = 3'd1;
                end
                for (int i = 0; i < STACK_DEPTH; i++)
                    if (DEPTH_W'(i) == d1)
                        ns[i] = serial_reg;
                nd = d1 + 1'b1;
            end
            mbsnt_pkg::MSG_NOTE_OFF:
            begin
                if (d != '0)
                begin
                    rs[0]  = mk_res(mbsnt_pkg::CMD_NOTE_OFF, 1'b1, top_serial, msg_reg.a,
                                    msg_reg.b);
                    cnt    = 3'd1;
                    nd     = d - 1'b1;
                    key_wr = 1'b1;
                end
            end
            mbsnt_pkg::MSG_PRESSURE:
            begin
                for (int i = 0; i < PRESS_N; i++)
                    if (DEPTH_W'(i) < d)
                        rs[i] = mk_res(mbsnt_pkg::CMD_POLY_PRESSURE, 1'b1, s[i], msg_reg.a,
                                       msg_reg.b);
                cnt = (32'(d) > PRESS_N) ? 3'(PRESS_N) : 3'(d);
            end
            mbsnt_pkg::MSG_MOD:
            begin
                rs[0] = mk_res(mbsnt_pkg::CMD_MODULATION, 1'b0, '0, 7'd0, msg_reg.b);
                cnt   = 3'd1;
            end
            mbsnt_pkg::MSG_SUSTAIN:
            begin
                rs[0] = mk_res(mbsnt_pkg::CMD_SUSTAIN, 1'b0, '0, 7'd0, msg_reg.b);
                cnt   = 3'd1;
            end
            mbsnt_pkg::MSG_BEND:
            begin
                rs[0]      = mk_res(mbsnt_pkg::CMD_PITCH_BEND, 1'b0, '0, 7'd0, 7'd0);
                rs[0].bend = {~msg_reg.b[6], msg_reg.b[5:0], msg_reg.a};
                cnt        = 3'd1;
            end
            mbsnt_pkg::MSG_PRESET:
            begin
                rs[0]        = mk_res(mbsnt_pkg::CMD_SET_PRESET, 1'b0, '0, 7'd0, 7'd0);
                rs[0].preset = mbsnt_pkg::preset_of(msg_reg.a);
                cnt          = 3'd1;
            end
            mbsnt_pkg::MSG_SOUND_OFF:
            begin
                rs[0] = mk_res(mbsnt_pkg::CMD_ALL_SOUND_OFF, 1'b0, '0, 7'd0, 7'd0);
                cnt   = 3'd1;
                clr   = 1'b1;
            end
            mbsnt_pkg::MSG_NOTES_OFF:
            begin
                rs[0] = mk_res(mbsnt_pkg::CMD_ALL_NOTES_OFF, 1'b0, '0, 7'd0, 7'd0);
                cnt   = 3'd1;
                clr   = 1'b1;
            end
            mbsnt_pkg::MSG_CTRL_RESET:
            begin
                rs[0] = mk_res(mbsnt_pkg::CMD_SUSTAIN, 1'b0, '0, 7'd0, 7'd0);
                rs[1] = mk_res(mbsnt_pkg::CMD_PITCH_BEND, 1'b0, '0, 7'd0, 7'd0);
                rs[2] = mk_res(mbsnt_pkg::CMD_MODULATION, 1'b0, '0, 7'd0, 7'd0);
                cnt   = 3'd3;
            end
            default:
            begin
                cnt = 3'd0;
            end
        endcase
    end

    // repack the row
    always_comb
    begin
        new_row = '0;
        new_row[ROW_W-1 -: DEPTH_W] = nd;
        for (int i = 0; i < STACK_DEPTH; i++)
            new_row[i*SW +: SW] = ns[i];
    end

    assign mem_we = (state_reg == ST_CLEAR) || (state_reg == ST_EXEC && key_wr);
    assign mem_wa = (state_reg == ST_CLEAR) ? clr_addr_reg : key;
    assign mem_wd = (state_reg == ST_CLEAR) ? '0 : new_row;

    // stack row memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            row_mem[mem_wa] <= mem_wd;
        row_reg <= row_mem[key];
    end

    assign pop     = (state_reg == ST_IDLE) && !q_empty;
    assign load_ok = !out_valid_reg || out_ready;
    assign is_last = ({1'b0, idx_reg} == (cnt_reg - 3'd1));

    // result list registers
    always_ff @(posedge clk)
    begin
        if (pop)
            msg_reg <= q_msg;
        if (state_reg == ST_EXEC)
            for (int i = 0; i < mbsnt_pkg::RESULT_CAP; i++)
                res_reg[i] <= rs[i];
        if (state_reg == ST_EMIT && load_ok)
        begin
            out_res_reg  <= res_reg[idx_reg];
            out_gid_reg  <= res_reg[idx_reg].has_id ?
                            {source_number, res_reg[idx_reg].serial} : 64'd0;
            out_last_reg <= is_last;
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            clear_pend_reg <= 1'b0;
            init_done_reg  <= 1'b0;
            serial_reg     <= SW'(1);
            cnt_reg        <= 3'd0;
            idx_reg        <= 2'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            // word taken and no new word loaded this cycle
            if (out_valid_reg && out_ready && !(state_reg == ST_EMIT && load_ok))
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_CLEAR:
                begin
                    if (clr_addr_reg == KEY_W'(KEY_COUNT - 1))
                    begin
                        clr_addr_reg   <= '0;
                        init_done_reg  <= 1'b1;
                        clear_pend_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                    else
                    begin
                        clr_addr_reg <= clr_addr_reg + 1'b1;
                    end
                end
                ST_IDLE:
                begin
                    if (!q_empty)
                        state_reg <= ST_READ;
                end
                ST_READ:
                begin
                    state_reg <= ST_EXEC;
                end
                ST_EXEC:
                begin
                    cnt_reg        <= cnt;
                    idx_reg        <= 2'd0;
                    clear_pend_reg <= clr;
                    serial_reg     <= next_serial;
                    state_reg      <= (cnt != 3'd0) ? ST_EMIT : ST_IDLE;
                end
                ST_EMIT:
                begin
                    if (load_ok)
                    begin
                        out_valid_reg <= 1'b1;
                        idx_reg       <= idx_reg + 1'b1;
                        if (is_last)
                            state_reg <= clear_pend_reg ? ST_CLEAR : ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign init_done  = init_done_reg;
    assign out_valid  = out_valid_reg;
    assign out_code   = out_res_reg.code;
    assign out_gid    = out_gid_reg;
    assign out_note   = out_res_reg.note;
    assign out_amount = out_res_reg.amount;
    assign out_bend   = out_res_reg.bend;
    assign out_preset = out_res_reg.preset;
    assign out_last   = out_last_reg;

endmodule

### rtl/core/mbsnt_checker.sv
// port-level checker for the note tracker, bound to the top level
`timescale 1ns / 1ps
`include "midi_byte_stream_note_tracker_macros.svh"
module mbsnt_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [103:0] m_tdata,
    input logic         m_tlast
);

    // a stalled word stays up and unchanged
    `MBSNT_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid, "output word dropped")
    `MBSNT_HOLD(a_out_stable, m_tvalid && !m_tready, m_tdata, "stalled word changed")

    // within a run, m_tvalid does not drop after a word that is not the last is taken
    `MBSNT_ASSERT(a_run_gapless, m_tvalid && m_tready && !m_tlast |=> m_tvalid, "run gap")

    // input not ready as reset ends and the stack rows start clearing
    `MBSNT_ASSERT(a_reset_sweep, $rose(rst_n) |-> !s_tready, "input ready during reset sweep")

endmodule

bind midi_byte_stream_note_tracker mbsnt_checker u_mbsnt_checker (.*);

### test/tb.sv
// testbench for the midi byte stream note tracker
`timescale 1ns / 1ps
module tb;

    localparam int DEPTH = 4;
    localparam int KEYS = 2048;
    localparam int WATCH_LIMIT = 20000;

    typedef struct packed {
        logic [3:0]  code;
        logic [63:0] gid;
        logic [6:0]  note;
        logic [6:0]  amount;
        logic [13:0] bend;
        logic [4:0]  preset;
        logic        last;
    } command_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;
    logic         m_tlast;
    logic         cfg_we;
    logic         cfg_index;
    logic [31:0]  cfg_data;

    midi_byte_stream_note_tracker i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor state
    logic [31:0] src_num;
    logic [4:0]  chan_sel;
    logic [7:0]  run_status;
    logic [1:0]  data_needed;
    logic [1:0]  data_held;
    logic [6:0]  first_data;
    logic        in_sysex;
    logic [1:0]  skip_left;
    logic [31:0] next_serial;
    logic [2:0]  depth_of [KEYS];
    logic [31:0] serial_of [KEYS*DEPTH];

    command_t expected_cmds[$];
    command_t step_cmds[$];
    int errors;
    int words_seen;
    int bytes_sent;
    int send_idle_pct;
    int recv_idle_pct;
    int quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [4:0] preset_for(input logic [6:0] p);
        if (p <= 3) return 5'd0;
        if (p <= 5) return 5'd1;
        if (p == 6) return 5'd2;
        if (p == 10) return 5'd3;
        if (p == 11) return 5'd4;
        if (p == 16) return 5'd5;
        if (p >= 17 && p <= 23) return 5'd6;
        if (p >= 24 && p <= 27) return 5'd7;
        if (p >= 28 && p <= 31) return 5'd8;
        if (p >= 32 && p <= 39) return 5'd9;
        if (p == 40 || p == 41) return 5'd10;
        if (p == 42 || p == 43) return 5'd11;
        if (p == 46) return 5'd12;
        if (p >= 52 && p <= 54) return 5'd13;
        if (p == 71 || p == 72) return 5'd14;
        if (p >= 73 && p <= 79) return 5'd15;
        if (p >= 80 && p <= 87) return 5'd16;
        if (p >= 88 && p <= 95) return 5'd17;
        return 5'd0;
    endfunction

    // queue one command for the current byte, capped per byte
    task automatic add_cmd(input logic [3:0] code, input logic [63:0] gid,
                           input logic [6:0] note, input logic [6:0] amt,
                           input logic [13:0] bend, input logic [4:0] preset);
        command_t c;
        if (step_cmds.size() >= mbsnt_pkg::RESULT_CAP) return;
        c = '{code, gid, note, amt, bend, preset, 1'b0};
        step_cmds.push_back(c);
    endtask

    function automatic logic [63:0] gesture(input logic [31:0] s);
        return {src_num, s};
    endfunction

    task automatic ctrl_defaults();
        add_cmd(mbsnt_pkg::CMD_SUSTAIN, 0, 0, 0, 0, 0);
        add_cmd(mbsnt_pkg::CMD_PITCH_BEND, 0, 0, 0, 0, 0);
        add_cmd(mbsnt_pkg::CMD_MODULATION, 0, 0, 0, 0, 0);
    endtask

    // one complete channel message
    task automatic run_message(input logic [7:0] status, input logic [6:0] a,
                               input logic [6:0] b);
        int key;
        int c;
        logic [31:0] s;
        logic [3:0] kind;
        kind = status[7:4];
        if (chan_sel != 0 && chan_sel != status[3:0] + 1) return;
        key = status[3:0] * 128 + a;
        if (kind == mbsnt_pkg::TYPE_NOTE_ON && b != 0)
        begin
            if (depth_of[key] >= DEPTH)
            begin
                add_cmd(mbsnt_pkg::CMD_NOTE_OFF, gesture(serial_of[key*DEPTH]), a, 0, 0, 0);
                for (int d = 1; d < DEPTH; d++)
                    serial_of[key*DEPTH+d-1] = serial_of[key*DEPTH+d];
                depth_of[key] = DEPTH - 1;
            end
            s = next_serial;
            next_serial = next_serial + 1;
            if (next_serial == 0) next_serial = 1;
            add_cmd(mbsnt_pkg::CMD_NOTE_ON, gesture(s), a, b, 0, 0);
            serial_of[key*DEPTH+depth_of[key]] = s;
            depth_of[key] = depth_of[key] + 1;
        end
        else if (kind == mbsnt_pkg::TYPE_POLY)
        begin
            for (int d = 0; d < depth_of[key]; d++)
                add_cmd(mbsnt_pkg::CMD_POLY_PRESSURE, gesture(serial_of[key*DEPTH+d]),
                        a, b, 0, 0);
        end
        else if (kind == mbsnt_pkg::TYPE_NOTE_ON || kind == mbsnt_pkg::TYPE_NOTE_OFF)
        begin
            c = depth_of[key];
            if (c != 0)
            begin
                add_cmd(mbsnt_pkg::CMD_NOTE_OFF, gesture(serial_of[key*DEPTH+c-1]), a,
                        kind == mbsnt_pkg::TYPE_NOTE_OFF ? b : 7'd0, 0, 0);
                depth_of[key] = c - 1;
            end
        end
        else if (kind == mbsnt_pkg::TYPE_CC)
        begin
            if (a == mbsnt_pkg::CC_MOD) add_cmd(mbsnt_pkg::CMD_MODULATION, 0, 0, b, 0, 0);
            else if (a == mbsnt_pkg::CC_SUSTAIN)
                add_cmd(mbsnt_pkg::CMD_SUSTAIN, 0, 0, b, 0, 0);
            else if (a == mbsnt_pkg::CC_CTRL_RESET) ctrl_defaults();
            else if (a == mbsnt_pkg::CC_SOUND_OFF || a == mbsnt_pkg::CC_NOTES_OFF)
            begin
                add_cmd(a == mbsnt_pkg::CC_SOUND_OFF ? mbsnt_pkg::CMD_ALL_SOUND_OFF :
                        mbsnt_pkg::CMD_ALL_NOTES_OFF, 0, 0, 0, 0, 0);
                foreach (depth_of[i]) depth_of[i] = 0;
            end
        end
        else if (kind == mbsnt_pkg::TYPE_PROGRAM)
            add_cmd(mbsnt_pkg::CMD_SET_PRESET, 0, 0, 0, 0, preset_for(a));
        else if (kind == mbsnt_pkg::TYPE_BEND)
            add_cmd(mbsnt_pkg::CMD_PITCH_BEND, 0, 0, 0, {b, a} - 14'd8192, 0);
    endtask

    // parse one byte and queue what it causes
    task automatic predict_byte(input logic [7:0] x);
        logic [6:0] a;
        logic [6:0] b;
        step_cmds.delete();
        if (chan_sel > 16) return;
        if (x >= mbsnt_pkg::BYTE_REALTIME)
        begin
            if (x == mbsnt_pkg::BYTE_RESET) ctrl_defaults();
        end
        else if (x[7])
        begin
            data_held = 0;
            if (x < mbsnt_pkg::BYTE_SYSEX)
            begin
                in_sysex = 0;
                skip_left = 0;
                run_status = x;
                data_needed = (x[7:4] == mbsnt_pkg::TYPE_PROGRAM ||
                               x[7:4] == mbsnt_pkg::TYPE_CHAN_PR) ? 1 : 2;
            end
            else
            begin
                run_status = 0;
                data_needed = 0;
                in_sysex = (x == mbsnt_pkg::BYTE_SYSEX);
                skip_left = (x == mbsnt_pkg::BYTE_MTC || x == mbsnt_pkg::BYTE_SONG_SEL) ? 2'd1 :
                            (x == mbsnt_pkg::BYTE_SONG_POS ? 2'd2 : 2'd0);
            end
        end
        else if (in_sysex)
        begin
        end
        else if (skip_left != 0)
            skip_left--;
        else if (run_status != 0)
        begin
            if (data_held == 0 && data_needed == 2)
            begin
                first_data = x[6:0];
                data_held = 1;
            end
            else
            begin
                a = data_needed == 2 ? first_data : x[6:0];
                b = data_needed == 2 ? x[6:0] : 7'd0;
                data_held = 0;
                run_message(run_status, a, b);
            end
        end
        if (step_cmds.size() > 0) step_cmds[step_cmds.size()-1].last = 1'b1;
        foreach (step_cmds[i]) expected_cmds.push_back(step_cmds[i]);
    endtask

    // send one byte and predict it on acceptance
    task automatic send_byte(input logic [7:0] x);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= x;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        predict_byte(x);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_msg(input logic [7:0] st, input logic [6:0] a, input logic [6:0] b);
        send_byte(st);
        send_byte({1'b0, a});
        if (st[7:4] != mbsnt_pkg::TYPE_PROGRAM && st[7:4] != mbsnt_pkg::TYPE_CHAN_PR)
            send_byte({1'b0, b});
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_cmds.size() != 0) @(negedge clk);
        repeat (2100) @(negedge clk);
    endtask

    // configuration write, block idle
    task automatic write_reg(input logic idx, input logic [31:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == 1'b0) src_num = v;
        else chan_sel = v[4:0];
    endtask

    // output checker
    always @(posedge clk)
    begin
        command_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            quiet_cycles = 0;
            words_seen++;
            if (expected_cmds.size() == 0)
            begin
                $error("unexpected word %h last %b", m_tdata, m_tlast);
                errors++;
            end
            else
            begin
                e = expected_cmds.pop_front();
                if (m_tdata[3:0] != e.code)
                begin
                    $error("command_code exp %0d got %0d", e.code, m_tdata[3:0]); errors++;
                end
                if (m_tdata[67:4] != e.gid)
                begin
                    $error("gid exp %h got %h", e.gid, m_tdata[67:4]); errors++;
                end
                if (m_tdata[74:68] != e.note)
                begin
                    $error("note_number exp %0d got %0d", e.note, m_tdata[74:68]); errors++;
                end
                if (m_tdata[81:75] != e.amount)
                begin
                    $error("amount exp %0d got %0d", e.amount, m_tdata[81:75]); errors++;
                end
                if (m_tdata[95:82] != e.bend)
                begin
                    $error("bend_value exp %h got %h", e.bend, m_tdata[95:82]); errors++;
                end
                if (m_tdata[100:96] != e.preset)
                begin
                    $error("preset_code exp %0d got %0d", e.preset, m_tdata[100:96]); errors++;
                end
                if (m_tlast != e.last)
                begin
                    $error("last_of_run exp %b got %b", e.last, m_tlast); errors++;
                end
            end
        end
        else if (rst_n && s_tvalid && s_tready)
            quiet_cycles = 0;
        else
            quiet_cycles++;
    end

    // receiver stalls
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    // watchdog on cycles with no accepted word or byte
    always @(posedge clk)
        if (quiet_cycles >= WATCH_LIMIT)
        begin
            $display("FAIL midi_byte_stream_note_tracker");
            $finish;
        end

    task automatic test_realtime_and_system();
        send_byte(8'hF8);
        send_byte(mbsnt_pkg::BYTE_RESET);
        send_byte(8'h45);
        send_byte(mbsnt_pkg::BYTE_SYSEX);
        send_byte(8'h12);
        send_byte(8'hF7);
        send_byte(mbsnt_pkg::BYTE_SONG_POS);
        send_byte(8'h01);
        send_byte(8'h7F);
        send_byte(mbsnt_pkg::BYTE_MTC);
        send_byte(8'h00);
        send_byte(8'hF4);
    endtask

    task automatic test_notes();
        // fill a stack past its depth, press, release, velocity zero, empty release
        for (int i = 0; i < 5; i++) send_msg(8'h90, 7'd127, 7'd1 + 7'(i));
        send_msg(8'hA0, 7'd127, 7'd127);
        send_msg(8'h80, 7'd127, 7'd127);
        send_byte(8'h00);
        send_byte(8'h00);
        send_msg(8'h9F, 7'd0, 7'd0);
        // running status
        send_msg(8'h95, 7'd60, 7'd100);
        send_byte(8'd60);
        send_byte(8'd0);
    endtask

    task automatic test_controllers();
        send_msg(8'hB0, mbsnt_pkg::CC_MOD, 7'd127);
        send_msg(8'hB1, mbsnt_pkg::CC_SUSTAIN, 7'd0);
        send_msg(8'hB2, mbsnt_pkg::CC_CTRL_RESET, 7'd0);
        send_msg(8'hB3, 7'd7, 7'd9);
        send_msg(8'hC4, 7'd16, 7'd0);
        send_msg(8'hC4, 7'd127, 7'd0);
        send_msg(8'hD0, 7'd5, 7'd0);
        send_msg(8'hE0, 7'd0, 7'd0);
        send_msg(8'hEF, 7'd127, 7'd127);
        send_msg(8'hB0, mbsnt_pkg::CC_SOUND_OFF, 7'd0);
        send_msg(8'hB0, mbsnt_pkg::CC_NOTES_OFF, 7'd0);
    endtask

    // mostly well formed messages on a few keys, some noise
    task automatic test_random(input int count);
        int pick;
        logic [7:0] st;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            st = {1'b1, 3'($urandom_range(0, 6)), 4'($urandom_range(0, 15))};
            if (pick < 45)
                st[7:4] = $urandom_range(1) ? mbsnt_pkg::TYPE_NOTE_ON : mbsnt_pkg::TYPE_NOTE_OFF;
            if (pick < 85)
                send_msg(st, 7'($urandom_range(2) == 0 ? $urandom_range(127) :
                                $urandom_range(60, 62)),
                         7'($urandom_range(4) == 0 ? 0 : $urandom_range(127)));
            else if (pick < 95)
                send_byte(8'($urandom));
            else if (pick < 98)
                send_msg(8'hB0 | 8'($urandom_range(15)),
                         $urandom_range(1) ? mbsnt_pkg::CC_SOUND_OFF :
                                             mbsnt_pkg::CC_CTRL_RESET, 7'd0);
            else
            begin
                // pause until everything is out
                s_tvalid <= 1'b0;
                while (expected_cmds.size() != 0) @(negedge clk);
                send_byte(8'($urandom));
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'h00;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_data = 32'h0;
        errors = 0;
        words_seen = 0;
        bytes_sent = 0;
        quiet_cycles = 0;
        send_idle_pct = 22;
        recv_idle_pct = 71;
        src_num = 0;
        chan_sel = 0;
        run_status = 0;
        data_needed = 0;
        data_held = 0;
        first_data = 0;
        in_sysex = 0;
        skip_left = 0;
        next_serial = 1;
        foreach (depth_of[i]) depth_of[i] = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_realtime_and_system();
        test_notes();
        test_controllers();
        write_reg(1'b0, 32'hFFFF_FFFF);
        write_reg(1'b1, 32'd16);
        test_random(20);
        write_reg(1'b1, 32'd31);
        test_random(8);
        write_reg(1'b1, 32'd1);
        write_reg(1'b0, 32'hA5C3_0001);
        send_idle_pct = 71;
        recv_idle_pct = 22;
        test_random(28);
        write_reg(1'b1, 32'd0);
        write_reg(1'b0, 32'h0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(36);
        drain();

        $display("covered %0d bytes and %0d command words", bytes_sent, words_seen);
        $display("channel filters 0, 1, 16 and invalid; source ids 0, all ones, mixed");
        if (errors == 0 && expected_cmds.size() == 0)
            $display("PASS midi_byte_stream_note_tracker");
        else
            $display("FAIL midi_byte_stream_note_tracker");
        $finish;
    end
endmodule

### files.f
+incdir+rtl/core
rtl/core/mbsnt_pkg.sv
rtl/core/mbsnt_front.sv
rtl/core/mbsnt_queue.sv
rtl/core/mbsnt_back.sv
rtl/core/midi_byte_stream_note_tracker.sv
rtl/core/mbsnt_checker.sv
test/tb.sv
